[hdl/sorv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sorv_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

    typedef struct packed {
        logic [12:0]        step_index;
        logic signed [15:0] profile_x;
        logic signed [15:0] profile_y;
        logic signed [15:0] normal_in_x;
        logic signed [15:0] normal_in_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic signed [15:0] normal_out_x;
        logic signed [15:0] normal_out_y;
        logic signed [15:0] normal_out_z;
        logic               zero_normal;
    } out_beat_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [12:0]        k;
        logic [12:0]        n;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               nz_zero;
    } work_t;

    function automatic logic [31:0] atan_turn(input int i);
        case (i)
            0: atan_turn = 32'd536870912;
            1: atan_turn = 32'd316933406;
            2: atan_turn = 32'd167458907;
            3: atan_turn = 32'd85004756;
            4: atan_turn = 32'd42667331;
            5: atan_turn = 32'd21354465;
            6: atan_turn = 32'd10679838;
            7: atan_turn = 32'd5340245;
            8: atan_turn = 32'd2670163;
            9: atan_turn = 32'd1335087;
            10: atan_turn = 32'd667544;
            11: atan_turn = 32'd333772;
            12: atan_turn = 32'd166886;
            13: atan_turn = 32'd83443;
            14: atan_turn = 32'd41721;
            default: atan_turn = 32'd20861;
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            sat16 = 16'sh7fff;
        else if (v < -64'sd32768)
            sat16 = 16'sh8000;
        else
            sat16 = v[15:0];
    endfunction

endpackage
`default_nettype wire

[hdl/surface_of_revolution_vertex_top.sv]
// path: an accepted input beat reaches out_valid through the front queue, then the
// pipelined mod, phase divide, cordic, square root and normalize stages
// throughput: one beat per cycle; the back pipe holds while a result beat waits
// under out_stall, and the two-entry front queue takes up to two more beats
// reset: rst_n asynchronous active low clears valids; step_count returns to 64
`timescale 1ns / 1ps
`default_nettype none
module surface_of_revolution_vertex_top
    import sorv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_beat_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_beat_t     out_data
);
    logic [12:0] step_count_reg;
    logic  q_valid, q_stall;
    work_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_count_reg <= 13'd64;
        else if (cfg_we)
            step_count_reg <= cfg_wdata;
    end

    sorv_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .step_count(step_count_reg),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
    );

    sorv_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_stall(q_stall),
        .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

`ifndef SYNTHESIS
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_normal |-> out_data.normal_out_x == 16'sd0
        && out_data.normal_out_y == 16'sd0 && out_data.normal_out_z == 16'sd0)
        else $error("zero normal flag with nonzero normal");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");
`endif
endmodule
`default_nettype wire

[hdl/sorv_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module sorv_front
    import sorv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_beat_t in_data,
    input  wire logic [12:0] step_count,
    output logic          q_valid,
    input  wire logic     q_stall,
    output work_t         q_data
);
    // classify each beat and buffer it in a two-entry queue; the index reduction
    // and the divides run one bit per stage in the back pipe
    localparam int DEPTH = 2;

    work_t    mem_reg [DEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic     wr_ptr_reg, rd_ptr_reg;
    logic [12:0] n_eff;
    work_t    w;
    logic     push, pop;

    assign n_eff = (step_count == 13'd0) ? 13'd1 : step_count;

    always_comb
    begin
        w.k       = in_data.step_index;
        w.n       = n_eff;
        w.px      = in_data.profile_x;
        w.py      = in_data.profile_y;
        w.nx      = in_data.normal_in_x;
        w.ny      = in_data.normal_in_y;
        w.nz_zero = (in_data.normal_in_x == 16'sd0) && (in_data.normal_in_y == 16'sd0);
    end

    assign in_stall = (cnt_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && !q_stall;
    assign q_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= w;
    end
endmodule
`default_nettype wire

[hdl/sorv_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module sorv_back
    import sorv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_stall,
    input  wire work_t q_data,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_beat_t  out_data
);
    // stage map: 13 mod steps, 1 phase setup, 32 phase divide steps, 16 cordic,
    // 1 quadrant fold, 1 product, 1 squares, 32 sqrt steps (2 bits each),
    // 1 normalize setup, 17 normalize divide steps (three in parallel), 1 flag
    localparam int S_MOD  = 13;
    localparam int S_PDIV = 33;
    localparam int S_COR  = CORDIC_ITERS;
    localparam int S_SQ   = 32;
    localparam int S_ND   = 18;
    localparam int LAT = S_MOD + S_PDIV + S_COR + 3 + S_SQ + S_ND + 1;

    typedef struct packed {
        logic [12:0]        n;
        logic [12:0]        rem;
        logic [44:0]        num;
        logic [44:0]        quo;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [33:0] cz;
        logic [1:0]         quad;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic               nzz;
        logic signed [15:0] vx;
        logic signed [15:0] vz;
        logic signed [47:0] a;
        logic signed [47:0] b;
        logic signed [47:0] c;
        logic [63:0]        sq_v;
        logic [63:0]        sq_r;
        logic [32:0]        len;
        logic [47:0]        rx;
        logic [47:0]        ry;
        logic [47:0]        rz;
        logic [47:0]        qx;
        logic [47:0]        qy;
        logic [47:0]        qz;
    } st_t;

    st_t pipe_reg [LAT+1];
    st_t pipe_next [LAT+1];
    logic [LAT:0] vld_reg;
    logic adv;

    // whole pipe advances only when the output is free
    assign adv     = !(out_valid && out_stall);
    assign q_stall = !adv;

    // one restoring divide step: {quotient bit, next partial remainder}
    function automatic logic [48:0] dstep(input logic [47:0] r, input logic nb,
                                          input logic [32:0] d);
        logic [47:0] sh;
        sh = {r[46:0], nb};
        if (sh >= {15'd0, d})
            dstep = {1'b1, sh - {15'd0, d}};
        else
            dstep = {1'b0, sh};
    endfunction

    function automatic st_t step(input st_t s, input int j);
        st_t o;
        logic [14:0] t;
        logic [14:0] tr;
        logic [31:0] ph;
        logic signed [33:0] dx, dy;
        logic [63:0] bit_v, trial;
        logic [31:0] ma, mb, mc;
        logic [47:0] nr;
        logic [48:0] dvx, dvy, dvz;
        int i;
        o = s;
        if (j < S_MOD)
        begin
            // restoring remainder of k by n
            t = {1'b0, s.rem, s.num[12 - j]} - {2'b0, s.n};
            o.rem = t[14] ? {s.rem[11:0], s.num[12 - j]} : t[12:0];
        end
        else if (j == S_MOD)
        begin
            // numerator (k mod n)*2^32 + n/2; rem stays as the starting remainder
            o.num = {s.rem, 32'd0} + {33'd0, s.n[12:1]};
            o.quo = 45'd0;
        end
        else if (j < S_MOD + S_PDIV)
        begin
            i = j - S_MOD - 1;
            // 32 quotient bits (high 13 are zero since k mod n < n)
            tr = {1'b0, s.rem, s.num[31 - i]} - {2'b0, s.n};
            o.rem = tr[14] ? {s.rem[11:0], s.num[31 - i]} : tr[12:0];
            o.quo = {s.quo[43:0], ~tr[14]};
            if (i == 31)
            begin
                ph     = {s.quo[30:0], ~tr[14]};
                o.quad = ph[31:30];
                o.cz   = {4'd0, ph[29:0]};
                o.cx   = CORDIC_KINV;
                o.cy   = 34'sd0;
            end
        end
        else if (j < S_MOD + S_PDIV + S_COR)
        begin
            i  = j - S_MOD - S_PDIV;
            dx = s.cy >>> i;
            dy = s.cx >>> i;
            if (!s.cz[33])
            begin
                o.cx = s.cx - dx;
                o.cy = s.cy + dy;
                o.cz = s.cz - $signed({2'b0, atan_turn(i)});
            end
            else
            begin
                o.cx = s.cx + dx;
                o.cy = s.cy - dy;
                o.cz = s.cz + $signed({2'b0, atan_turn(i)});
            end
        end
        else if (j == S_MOD + S_PDIV + S_COR)
        begin
            // quarter turn fold into (cx=cos, cy=sin)
            case (s.quad)
                2'd0: begin o.cx = s.cx;  o.cy = s.cy;  end
                2'd1: begin o.cx = -s.cy; o.cy = s.cx;  end
                2'd2: begin o.cx = -s.cx; o.cy = -s.cy; end
                default: begin o.cx = s.cy; o.cy = -s.cx; end
            endcase
        end
        else if (j == S_MOD + S_PDIV + S_COR + 1)
        begin
            o.vx = sat16(((64'(s.px) * 64'(s.cx)) + 64'sd536870912) >>> 30);
            o.vz = sat16(((-(64'(s.px) * 64'(s.cy))) + 64'sd536870912) >>> 30);
            o.a  = 48'((64'(s.nx) * 64'(s.cx) + 64'sd8192) >>> 14);
            o.b  = 48'(64'(s.ny) <<< 16);
            o.c  = 48'((-(64'(s.nx) * 64'(s.cy)) + 64'sd8192) >>> 14);
        end
        else if (j == S_MOD + S_PDIV + S_COR + 2)
        begin
            // magnitudes stay below 2^32, squares sum fits 64 bits
            ma = 32'(s.a < 0 ? -s.a : s.a);
            mb = 32'(s.b < 0 ? -s.b : s.b);
            mc = 32'(s.c < 0 ? -s.c : s.c);
            o.sq_v = 64'(ma) * 64'(ma) + 64'(mb) * 64'(mb) + 64'(mc) * 64'(mc);
            o.sq_r = 64'd0;
        end
        else if (j < S_MOD + S_PDIV + S_COR + 3 + S_SQ)
        begin
            i = j - (S_MOD + S_PDIV + S_COR + 3);
            bit_v = 64'd1 << (62 - 2 * i);
            trial = s.sq_r + bit_v;
            if (s.sq_v >= trial)
            begin
                o.sq_v = s.sq_v - trial;
                o.sq_r = (s.sq_r >> 1) + bit_v;
            end
            else
                o.sq_r = s.sq_r >> 1;
            if (i == S_SQ - 1)
            begin
                o.len = o.sq_r[32:0];
                o.rx = 48'd0; o.ry = 48'd0; o.rz = 48'd0;
                o.qx = 48'd0; o.qy = 48'd0; o.qz = 48'd0;
            end
        end
        else if (j < LAT - 1)
        begin
            // three restoring dividers, one quotient bit per stage; mag <= len,
            // so the quotient of mag*2^14 + len/2 fits in 17 bits
            i = j - (S_MOD + S_PDIV + S_COR + 3 + S_SQ);
            if (i == 0)
            begin
                ma = 32'(s.a < 0 ? -s.a : s.a);
                mb = 32'(s.b < 0 ? -s.b : s.b);
                mc = 32'(s.c < 0 ? -s.c : s.c);
                nr = ({16'd0, ma} << 14) + 48'(s.len >> 1);
                o.rx = nr >> 17;
                o.qx = {31'd0, nr[16:0]};
                nr = ({16'd0, mb} << 14) + 48'(s.len >> 1);
                o.ry = nr >> 17;
                o.qy = {31'd0, nr[16:0]};
                nr = ({16'd0, mc} << 14) + 48'(s.len >> 1);
                o.rz = nr >> 17;
                o.qz = {31'd0, nr[16:0]};
            end
            else
            begin
                // numerator bits shift out of q while quotient bits shift in
                dvx = dstep(s.rx, s.qx[16], s.len);
                dvy = dstep(s.ry, s.qy[16], s.len);
                dvz = dstep(s.rz, s.qz[16], s.len);
                o.rx = dvx[47:0];
                o.ry = dvy[47:0];
                o.rz = dvz[47:0];
                o.qx = {31'd0, s.qx[15:0], dvx[48]};
                o.qy = {31'd0, s.qy[15:0], dvy[48]};
                o.qz = {31'd0, s.qz[15:0], dvz[48]};
            end
        end
        else
        begin
            o.nzz = s.nzz || (s.len == 33'd0);
        end
        return o;
    endfunction

    always_comb
    begin
        pipe_next[0]     = '0;
        pipe_next[0].n   = q_data.n;
        pipe_next[0].num = {32'd0, q_data.k};
        pipe_next[0].px  = q_data.px;
        pipe_next[0].py  = q_data.py;
        pipe_next[0].nx  = q_data.nx;
        pipe_next[0].ny  = q_data.ny;
        pipe_next[0].nzz = q_data.nz_zero;
        for (int j = 0; j < LAT; j++)
            pipe_next[j + 1] = step(pipe_reg[j], j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-1:0], q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j <= LAT; j++)
                pipe_reg[j] <= pipe_next[j];
        end
    end

    function automatic logic signed [15:0] ncomp(input logic signed [47:0] c,
                                                 input logic [47:0] q);
        logic [16:0] r;
        r = (q > 48'd65536) ? 17'd65536 : q[16:0];
        ncomp = sat16(c < 0 ? 64'(r) : -64'(r));
    endfunction

    assign out_valid = vld_reg[LAT];
    always_comb
    begin
        out_data.vertex_x     = pipe_reg[LAT].vx;
        out_data.vertex_y     = pipe_reg[LAT].py;
        out_data.vertex_z     = pipe_reg[LAT].vz;
        out_data.zero_normal  = pipe_reg[LAT].nzz;
        out_data.normal_out_x = pipe_reg[LAT].nzz ? 16'sd0
                              : ncomp(pipe_reg[LAT].a, pipe_reg[LAT].qx);
        out_data.normal_out_y = pipe_reg[LAT].nzz ? 16'sd0
                              : ncomp(pipe_reg[LAT].b, pipe_reg[LAT].qy);
        out_data.normal_out_z = pipe_reg[LAT].nzz ? 16'sd0
                              : ncomp(pipe_reg[LAT].c, pipe_reg[LAT].qz);
    end
endmodule
`default_nettype wire
